// ===== hw/rtl/hlt_pkg.sv =====
// Package for the heap LRU tracker: sizes, operation codes, FSM states.
// No dependencies.
package hlt_pkg;
    localparam int BLOCK_COUNT = 1024;
    localparam int AW = (BLOCK_COUNT > 1) ? $clog2(BLOCK_COUNT) : 1;
    localparam int IDW = 10;
    localparam int TW = 64;

    localparam logic OP_ACCESS = 1'b0;
    localparam logic OP_SET    = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_STAMP,
        ST_RD_CUR,
        ST_RD_NB1,
        ST_RD_NB2,
        ST_DECIDE,
        ST_SWAP2,
        ST_ROOT,
        ST_ROOT_T,
        ST_OUT
    } state_t;
endpackage

// ===== hw/rtl/hlt_ram.sv =====
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
module hlt_ram #(
    parameter int DW = 8,
    parameter int AW = 4
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] addr,
    input  logic [DW-1:0] wdata,
    output logic [DW-1:0] rdata
);
    logic [DW-1:0] mem [2**AW];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// ===== hw/rtl/heap_lru_tracker.sv =====
// Top level of the heap LRU tracker: sequencer plus order, position, time RAMs.
// Depends on hlt_pkg and hlt_ram.
//
//  channel | dir | tdata fields (low bit up)
//  s_axis  | in  | operation[0], block_id[10:1], time_value[74:11]
//  m_axis  | out | lru_block_id[9:0], lru_time[73:10], clock_now[137:74]
//
// After reset a clearing pass writes identity order, identity positions and
// zero times into every entry, with s_tready low. An item then runs lookup,
// stamp, and per heap level a read, compare and swap round until no neighbor
// wins, up to 10 swap levels for 1024 blocks, then reads the root; each RAM
// has a single port. One item is in flight; the result register holds while
// m_tready is low and the next item waits until it is taken.
module heap_lru_tracker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [79:0]  s_tdata,  // operation, block_id, time_value, zero pad
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [143:0] m_tdata   // lru_block_id, lru_time, clock_now, zero pad
);
    import hlt_pkg::*;

    state_t state_reg, state_next;
    logic          clr_reg;
    logic [AW:0]   clr_cnt_reg;
    logic [TW-1:0] clock_reg;
    logic          op_reg;
    logic [IDW-1:0] blk_reg;
    logic [TW-1:0] tv_reg, t_new_reg;
    logic          down_reg;
    logic [AW:0]   pos_reg, nb1_reg, nb2_reg;
    logic [AW-1:0] cur_id_reg, nb1_id_reg, nb2_id_reg;
    logic [TW-1:0] cur_t_reg, nb1_t_reg;
    logic          nb1_ok_reg, nb2_ok_reg;
    logic [IDW-1:0] res_id_reg;
    logic [AW-1:0]  res_idn_reg;
    logic [TW-1:0]  res_t_reg, res_clk_reg;
    logic          m_valid_reg;

    // RAM ports
    logic          ord_we, pos_we, tim_we;
    logic [AW-1:0] ord_a, pos_a, tim_a;
    logic [AW-1:0] ord_wd, pos_wd, ord_rd, pos_rd;
    logic [TW-1:0] tim_wd, tim_rd;

    hlt_ram #(.DW(AW), .AW(AW)) u_ord (.aclk, .we(ord_we), .addr(ord_a),
        .wdata(ord_wd), .rdata(ord_rd));
    hlt_ram #(.DW(AW), .AW(AW)) u_pos (.aclk, .we(pos_we), .addr(pos_a),
        .wdata(pos_wd), .rdata(pos_rd));
    hlt_ram #(.DW(TW), .AW(AW)) u_tim (.aclk, .we(tim_we), .addr(tim_a),
        .wdata(tim_wd), .rdata(tim_rd));

    logic in_fire;
    assign s_tready = (state_reg == ST_IDLE) && !clr_reg && !m_valid_reg;
    assign in_fire  = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, res_clk_reg, res_t_reg, res_id_reg};

    logic blk_in_range;
    assign blk_in_range = ({22'd0, blk_reg} < 32'(BLOCK_COUNT));

    // best child during sift down; swap with a larger parent during sift up
    logic take1, take2, do_swap;
    logic [AW:0]   tgt_pos;
    logic [AW-1:0] tgt_id;
    always_comb begin
        take1 = 1'b0;
        take2 = 1'b0;
        if (down_reg) begin
            take1 = nb1_ok_reg && (nb1_t_reg < cur_t_reg);
            take2 = nb2_ok_reg && (tim_rd < (take1 ? nb1_t_reg : cur_t_reg));
        end else begin
            take1 = nb1_ok_reg && (cur_t_reg < nb1_t_reg);
        end
        do_swap = take1 || take2;
        tgt_pos = take2 ? nb2_reg : nb1_reg;
        tgt_id  = take2 ? nb2_id_reg : nb1_id_reg;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (in_fire) state_next = ST_LOOKUP;
            ST_LOOKUP: state_next = blk_in_range ? ST_STAMP : ST_ROOT;
            ST_STAMP:  state_next = ST_RD_CUR;
            ST_RD_CUR: state_next = ST_RD_NB1;
            ST_RD_NB1: state_next = nb1_ok_reg ? ST_RD_NB2 : ST_ROOT;
            ST_RD_NB2: state_next = ST_DECIDE;
            ST_DECIDE: state_next = do_swap ? ST_SWAP2 : ST_ROOT;
            ST_SWAP2:  state_next = ST_RD_CUR;
            ST_ROOT:   state_next = ST_ROOT_T;
            ST_ROOT_T: state_next = ST_OUT;
            ST_OUT:    state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // neighbor positions for the current position
    logic [AW:0] lchild, rchild, parent, nb1_pos;
    assign lchild  = {pos_reg[AW-1:0], 1'b1};
    assign rchild  = lchild + 1'b1;
    assign parent  = (pos_reg - 1'b1) >> 1;
    assign nb1_pos = down_reg ? lchild : parent;

    // RAM addressing per state
    always_comb begin
        ord_we = 1'b0; pos_we = 1'b0; tim_we = 1'b0;
        ord_a = '0; pos_a = '0; tim_a = '0;
        ord_wd = '0; pos_wd = '0; tim_wd = '0;
        if (clr_reg) begin
            ord_we = 1'b1; pos_we = 1'b1; tim_we = 1'b1;
            ord_a = clr_cnt_reg[AW-1:0]; pos_a = clr_cnt_reg[AW-1:0];
            tim_a = clr_cnt_reg[AW-1:0];
            ord_wd = clr_cnt_reg[AW-1:0]; pos_wd = clr_cnt_reg[AW-1:0];
        end else begin
            case (state_reg)
                ST_LOOKUP: begin
                    pos_a = AW'(blk_reg);
                    tim_a = AW'(blk_reg);
                end
                ST_STAMP: begin
                    tim_we = 1'b1; tim_a = AW'(blk_reg); tim_wd = t_new_reg;
                end
                ST_RD_CUR: ord_a = nb1_pos[AW-1:0];
                ST_RD_NB1: begin
                    ord_a = nb2_reg[AW-1:0];
                    tim_a = ord_rd;
                end
                ST_RD_NB2: tim_a = ord_rd;
                ST_DECIDE: if (do_swap) begin
                    ord_we = 1'b1; ord_a = pos_reg[AW-1:0]; ord_wd = tgt_id;
                    pos_we = 1'b1; pos_a = tgt_id; pos_wd = pos_reg[AW-1:0];
                end
                ST_SWAP2: begin
                    ord_we = 1'b1; ord_a = nb1_reg[AW-1:0]; ord_wd = cur_id_reg;
                    pos_we = 1'b1; pos_a = cur_id_reg; pos_wd = nb1_reg[AW-1:0];
                end
                ST_ROOT:   ord_a = '0;
                ST_ROOT_T: tim_a = ord_rd;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            clr_reg     <= 1'b1;
            clr_cnt_reg <= '0;
            clock_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (clr_reg) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == (AW+1)'(BLOCK_COUNT - 1)) clr_reg <= 1'b0;
            end
            if (in_fire && s_tdata[0] == OP_ACCESS) clock_reg <= clock_reg + 1'b1;
            if (state_reg == ST_OUT) m_valid_reg <= 1'b1;
            else if (m_valid_reg && m_tready) m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: if (in_fire) begin
                op_reg  <= s_tdata[0];
                blk_reg <= s_tdata[10:1];
                tv_reg  <= s_tdata[74:11];
            end
            ST_LOOKUP: t_new_reg <= (op_reg == OP_ACCESS) ? clock_reg : tv_reg;
            ST_STAMP: begin
                pos_reg <= {1'b0, pos_rd};
                down_reg <= t_new_reg > tim_rd;
                cur_t_reg <= t_new_reg;
                cur_id_reg <= AW'(blk_reg);
            end
            ST_RD_CUR: begin
                // nb1 = left child or parent; nb2 = right child
                if (down_reg) begin
                    nb1_reg <= lchild;
                    nb1_ok_reg <= lchild < (AW+1)'(BLOCK_COUNT);
                    nb2_reg <= rchild;
                    nb2_ok_reg <= rchild < (AW+1)'(BLOCK_COUNT);
                end else begin
                    nb1_reg <= parent;
                    nb1_ok_reg <= pos_reg != '0;
                    nb2_reg <= parent;
                    nb2_ok_reg <= 1'b0;
                end
            end
            ST_RD_NB1: begin
                nb1_id_reg <= ord_rd;
            end
            ST_RD_NB2: begin
                nb2_id_reg <= ord_rd;
                nb1_t_reg  <= tim_rd;
            end
            ST_DECIDE: begin
                nb1_reg <= tgt_pos;
                nb1_id_reg <= tgt_id;
            end
            ST_SWAP2: pos_reg <= nb1_reg;
            ST_ROOT_T: res_idn_reg <= ord_rd;
            ST_OUT: begin
                res_id_reg  <= IDW'(res_idn_reg);
                res_t_reg   <= tim_rd;
                res_clk_reg <= clock_reg;
            end
            default: ;
        endcase
    end
endmodule

// ===== hw/rtl/hlt_checker.sv =====
// Port-level checker for the heap LRU tracker, bound to the top level.
// Depends on heap_lru_tracker ports only.
module hlt_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic [79:0]  s_tdata,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [143:0] m_tdata
);
    a_no_accept_with_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready) else $error("input taken while result pending");
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready) else $error("second beat accepted");
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result dropped");
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[143:138] == 6'd0)) else $error("pad bits set");
endmodule

bind heap_lru_tracker hlt_checker u_hlt_checker (.*);

// ===== tb/heap_lru_tracker_tb.sv =====
`timescale 1ns / 100ps
// Testbench for heap_lru_tracker: drives access and set-time beats, predicts the
// LRU root, its time and the clock with a heap model. Depends on hlt_pkg.
module heap_lru_tracker_tb;
    import hlt_pkg::*;

    typedef struct packed {
        logic [TW-1:0]  clk_now;
        logic [TW-1:0]  lru_t;
        logic [IDW-1:0] blk;
    } lru_result_t;

    int err_count = 0;

    task automatic report(input string what, input logic [TW-1:0] got, input logic [TW-1:0] want);
        err_count++;
        $display("mismatch %s: got %0h want %0h", what, got, want);
    endtask

    class lru_scoreboard;
        logic [AW-1:0]  order_q[BLOCK_COUNT];
        logic [AW-1:0]  pos_q[BLOCK_COUNT];
        logic [TW-1:0]  stamp_q[BLOCK_COUNT];
        logic [TW-1:0]  clock_q;
        lru_result_t    pending[$];

        function new();
            for (int i = 0; i < BLOCK_COUNT; i++) begin
                order_q[i] = AW'(i);
                pos_q[i] = AW'(i);
                stamp_q[i] = '0;
            end
            clock_q = '0;
        endfunction

        function logic [TW-1:0] t_at(int p);
            return stamp_q[order_q[p]];
        endfunction

        function void swap_pos(int a, int b);
            logic [AW-1:0] t;
            t = order_q[a];
            order_q[a] = order_q[b];
            order_q[b] = t;
            pos_q[order_q[a]] = AW'(a);
            pos_q[order_q[b]] = AW'(b);
        endfunction

        function void note_input(logic op, logic [IDW-1:0] blk, logic [TW-1:0] tv);
            logic [TW-1:0] t;
            logic [TW-1:0] old;
            int p;
            int l;
            int r;
            int m;
            lru_result_t res;
            if (op == OP_ACCESS) begin
                clock_q = clock_q + 1;
                t = clock_q;
            end else begin
                t = tv;
            end
            if (blk < BLOCK_COUNT) begin
                old = stamp_q[blk];
                p = pos_q[blk];
                stamp_q[blk] = t;
                if (t > old) begin
                    forever begin
                        l = 2 * p + 1;
                        r = 2 * p + 2;
                        m = p;
                        if (l < BLOCK_COUNT && t_at(l) < t_at(m)) m = l;
                        if (r < BLOCK_COUNT && t_at(r) < t_at(m)) m = r;
                        if (m == p) break;
                        swap_pos(p, m);
                        p = m;
                    end
                end else begin
                    while (p > 0 && t_at(p) < t_at((p - 1) / 2)) begin
                        swap_pos(p, (p - 1) / 2);
                        p = (p - 1) / 2;
                    end
                end
            end
            res.blk = order_q[0];
            res.lru_t = stamp_q[order_q[0]];
            res.clk_now = clock_q;
            pending.push_back(res);
        endfunction

        task check_result(lru_result_t got);
            lru_result_t want;
            if (pending.size() == 0) begin
                report("unexpected beat", got.blk, 0);
                return;
            end
            want = pending.pop_front();
            if (got.blk !== want.blk) report("lru_block_id", got.blk, want.blk);
            if (got.lru_t !== want.lru_t) report("lru_time", got.lru_t, want.lru_t);
            if (got.clk_now !== want.clk_now) report("clock_now", got.clk_now, want.clk_now);
        endtask
    endclass

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [79:0]  s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [143:0] m_tdata;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_off = 0;
    int quiet_cycles = 0;
    lru_scoreboard board;

    heap_lru_tracker uut (.*);

    always #4 aclk = ~aclk;

    // Receiver: random stalls plus a long hold-off counted here.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            board.check_result(m_tdata[2*TW+IDW-1:0]);
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 20000) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic send_beat(input logic op, input logic [IDW-1:0] blk,
                             input logic [TW-1:0] tv);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tdata <= {5'b0, tv, blk, op};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        board.note_input(op, blk, tv);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.pending.size() != 0) @(posedge aclk);
    endtask

    // Mostly accesses to a small hot set so the heap order keeps shifting.
    task automatic random_beats(input int n);
        logic op;
        logic [IDW-1:0] blk;
        logic [TW-1:0] tv;
        for (int i = 0; i < n; i++) begin
            op = ($urandom_range(99) < 25) ? OP_SET : OP_ACCESS;
            blk = IDW'(($urandom_range(3) == 0) ? $urandom : $urandom_range(15));
            case ($urandom_range(3))
                0: tv = {$urandom, $urandom};
                1: tv = board.clock_q + $urandom_range(4) - 2;
                2: tv = $urandom_range(3);
                default: tv = {32'hffff_ffff, $urandom} | 64'h1;
            endcase
            send_beat(op, blk, tv);
        end
    endtask

    initial begin
        board = new();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        // Directed: extremes, both operations, equal time.
        send_beat(OP_ACCESS, 10'd0, '0);
        send_beat(OP_ACCESS, 10'd1023, '1);
        send_beat(OP_SET, 10'd1023, '0);
        send_beat(OP_SET, 10'd5, 64'd0);
        send_beat(OP_SET, 10'd512, '1);
        send_beat(OP_SET, 10'd512, '1);
        send_beat(OP_SET, 10'd0, 64'd1);
        send_beat(OP_SET, 10'd7, 64'h5555_5555_5555_5555);
        send_beat(OP_SET, 10'd7, 64'haaaa_aaaa_aaaa_aaaa);
        send_beat(OP_SET, 10'd341, 64'h0);
        send_beat(OP_SET, 10'd682, 64'h0);
        // Three accesses to blocks 3 to 5 advance the clock.
        for (int i = 0; i < 3; i++) send_beat(OP_ACCESS, IDW'(3 + i), '0);
        drain();
        board.clock_q = board.clock_q; // clock can only be moved by accesses
        random_beats(120);
        send_idle_pct = 87;
        random_beats(80);
        send_idle_pct = 0;
        recv_stall_pct = 87;
        random_beats(80);
        send_idle_pct = 22;
        recv_stall_pct = 22;
        random_beats(80);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off = 400;
        random_beats(60);
        drain();
        random_beats(80);
        drain();
        repeat (200) @(posedge aclk);
        if (err_count == 0 && board.pending.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

// ===== sim.f =====
hw/rtl/hlt_pkg.sv
hw/rtl/hlt_ram.sv
hw/rtl/heap_lru_tracker.sv
hw/rtl/hlt_checker.sv
tb/heap_lru_tracker_tb.sv
